// ===== src/lbbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lbbr_pkg
// Shared constants and types for the longest balanced bracket run block.
// ----------------------------------------------------------------------------
`default_nettype none

package lbbr_pkg;

    // Stack capacity in entries and bracket kind width
    localparam int STACK_DEPTH = 4096;
    localparam int TYPE_WIDTH  = 8;

    // Token position and result length width, fixed by the result field
    localparam int POS_WIDTH   = 12;
    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    // Stack addressing; the count also holds the full depth
    localparam int ADDR_WIDTH  = $clog2(STACK_DEPTH);
    localparam int COUNT_WIDTH = ADDR_WIDTH + 1;

    // One stack entry: position, kind and barrier mark
    typedef struct packed {
        logic [POS_WIDTH-1:0]  pos;
        logic [TYPE_WIDTH-1:0] kind;
        logic                  barrier;
    } entry_t;

    localparam int ENTRY_WIDTH = $bits(entry_t);

    // Bottom entry after reset: position 0, kind 0, barrier
    localparam entry_t SENTINEL = '{pos: '0, kind: '0, barrier: 1'b1};

endpackage

`default_nettype wire

// ===== src/lbbr_ram.sv =====
// ----------------------------------------------------------------------------
// lbbr_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lbbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write on enable, register the read data
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/longest_balanced_bracket_run.sv =====
// ----------------------------------------------------------------------------
// longest_balanced_bracket_run
// Streams bracket tokens and reports the longest balanced contiguous run.
// ----------------------------------------------------------------------------
// Each request is one bracket token (open or close of a numbered kind, with a
// last mark). The block takes one token per cycle, back to back; only a last
// token is held off while a result waits on the output. In the cycle after a
// token with last is taken it delivers one result: the longest balanced run of
// the sequence, or the overflow flag if the sequence ran past 4095 tokens or
// past STACK_DEPTH stacked entries. The position stack lives in a
// single-port-write RAM with registered read; the top two entries are held in
// registers and the third is read ahead every cycle, with write-to-read
// forwarding, so the one RAM port pair sets the rate of one token per cycle.
// State clears itself after each last token; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module longest_balanced_bracket_run
    import lbbr_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_is_close,
    input  wire logic [TYPE_WIDTH-1:0] s_bracket_type,
    input  wire logic                  s_last,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic      [POS_WIDTH-1:0]  m_longest_length,
    output logic                       m_overflow
);

    // Stack state: count, cached top and second entries
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    entry_t                 top_reg, top_next;
    entry_t                 second_reg, second_next;
    logic [POS_WIDTH-1:0]   pos_reg, pos_next;
    logic [POS_WIDTH-1:0]   best_reg, best_next;
    logic                   ovf_reg, ovf_next;

    // Forwarding of a write that hits the read-ahead address
    logic                   fwd_hit_reg, fwd_hit_next;
    entry_t                 fwd_data_reg, fwd_data_next;

    // Output register
    logic                   m_valid_reg, m_valid_next;
    logic [POS_WIDTH-1:0]   m_len_reg, m_len_next;
    logic                   m_ovf_reg, m_ovf_next;

    // RAM ports
    logic                   ram_we;
    logic [ADDR_WIDTH-1:0]  ram_waddr;
    logic [ADDR_WIDTH-1:0]  ram_raddr;
    entry_t                 ram_wdata;
    logic [ENTRY_WIDTH-1:0] ram_rdata;

    logic                   accept;
    logic                   match;
    entry_t                 third;
    logic [POS_WIDTH-1:0]   here;
    logic [POS_WIDTH-1:0]   span;
    logic [COUNT_WIDTH-1:0] spill_idx;
    logic [COUNT_WIDTH-1:0] ahead_idx;

    lbbr_ram #(
        .WIDTH (ENTRY_WIDTH),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Hold off only a last request while the result slot stays full
    assign s_ready = !m_valid_reg || m_ready || !s_last;
    assign accept  = s_valid && s_ready;

    // Third entry from the read-ahead, or the forwarded write
    assign third = fwd_hit_reg ? fwd_data_reg : entry_t'(ram_rdata);

    assign here  = pos_reg + POS_WIDTH'(1);
    assign span  = here - second_reg.pos;
    assign match = !top_reg.barrier && (top_reg.kind == s_bracket_type)
                   && (count_reg >= COUNT_WIDTH'(2));

    assign spill_idx = count_reg - COUNT_WIDTH'(2);

    // Update stack, position, best length and overflow for an accepted request
    always_comb begin
        count_next   = count_reg;
        top_next     = top_reg;
        second_next  = second_reg;
        pos_next     = pos_reg;
        best_next    = best_reg;
        ovf_next     = ovf_reg;
        ram_we       = 1'b0;
        ram_waddr    = spill_idx[ADDR_WIDTH-1:0];
        ram_wdata    = second_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_len_next   = m_len_reg;
        m_ovf_next   = m_ovf_reg;

        if (accept) begin
            if (!ovf_reg) begin
                if (pos_reg >= POS_MAX) begin
                    ovf_next = 1'b1;
                end else begin
                    pos_next = here;
                    if (!s_is_close) begin
                        if (count_reg >= COUNT_WIDTH'(STACK_DEPTH)) begin
                            ovf_next = 1'b1;
                        end else begin
                            // Push: spill the second entry to the RAM
                            top_next    = '{pos: here, kind: s_bracket_type, barrier: 1'b0};
                            second_next = top_reg;
                            count_next  = count_reg + COUNT_WIDTH'(1);
                            ram_we      = (count_reg >= COUNT_WIDTH'(2));
                        end
                    end else if (match) begin
                        // Pop the matched open and score the span
                        count_next  = count_reg - COUNT_WIDTH'(1);
                        top_next    = second_reg;
                        second_next = third;
                        if (span > best_reg) begin
                            best_next = span;
                        end
                    end else begin
                        // Replace the top with this close as a barrier
                        top_next = '{pos: here, kind: s_bracket_type, barrier: 1'b1};
                    end
                end
            end

            if (s_last) begin
                // Load the result and return to the empty sequence
                m_valid_next = 1'b1;
                m_len_next   = ovf_next ? '0 : best_next;
                m_ovf_next   = ovf_next;
                count_next   = COUNT_WIDTH'(1);
                top_next     = SENTINEL;
                pos_next     = '0;
                best_next    = '0;
                ovf_next     = 1'b0;
            end
        end
    end

    // Read ahead the entry below the next second entry
    assign ahead_idx     = count_next - COUNT_WIDTH'(3);
    assign ram_raddr     = ahead_idx[ADDR_WIDTH-1:0];
    assign fwd_hit_next  = ram_we && (ram_waddr == ram_raddr);
    assign fwd_data_next = ram_wdata;

    // Advance registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= COUNT_WIDTH'(1);
            top_reg     <= SENTINEL;
            pos_reg     <= '0;
            best_reg    <= '0;
            ovf_reg     <= 1'b0;
            fwd_hit_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            top_reg     <= top_next;
            pos_reg     <= pos_next;
            best_reg    <= best_next;
            ovf_reg     <= ovf_next;
            fwd_hit_reg <= fwd_hit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers need no reset
    always_ff @(posedge aclk) begin
        second_reg   <= second_next;
        fwd_data_reg <= fwd_data_next;
        m_len_reg    <= m_len_next;
        m_ovf_reg    <= m_ovf_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_longest_length = m_len_reg;
    assign m_overflow       = m_ovf_reg;

endmodule

`default_nettype wire
